/* src/tga_rle_pixel_decoder_macros.svh */
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder_macros.svh
// Assertion macros used by the run-length pixel decoder core
// ----------------------------------------------------------------------------
`ifndef TGA_RLE_PIXEL_DECODER_MACROS_SVH
`define TGA_RLE_PIXEL_DECODER_MACROS_SVH

// same-cycle implication, checked out of reset
`define TGARD_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define TGARD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/tgard_pkg.sv */
// ----------------------------------------------------------------------------
// tgard_pkg
// Types, constants and helper functions of the run-length pixel decoder
// ----------------------------------------------------------------------------
package tgard_pkg;

  localparam logic [1:0] CFG_IDX_BPP    = 2'd0;
  localparam logic [1:0] CFG_IDX_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_IDX_HEIGHT = 2'd2;

  localparam logic [2:0] BPP_RESET     = 3'd4;
  localparam logic [7:0] RLE_RUN_FLAG  = 8'd128;
  localparam logic [7:0] RLE_RUN_BIAS  = 8'd127;

  typedef struct packed {
    logic [2:0]  bpp;
    logic [31:0] total;
  } cfg_t;

  function automatic logic [2:0] eff_bpp(input logic [2:0] raw);
    logic [2:0] res;
    if (raw == 3'd0) begin
      res = 3'd1;
    end else if (raw > 3'd4) begin
      res = 3'd4;
    end else begin
      res = raw;
    end
    return res;
  endfunction

  function automatic logic [31:0] pixel_mask(input logic [2:0] bpp);
    logic [31:0] res;
    unique case (bpp)
      3'd1:    res = 32'h0000_00FF;
      3'd2:    res = 32'h0000_FFFF;
      3'd3:    res = 32'h00FF_FFFF;
      default: res = 32'hFFFF_FFFF;
    endcase
    return res;
  endfunction

endpackage

/* src/tgard_cfg.sv */
// ----------------------------------------------------------------------------
// tgard_cfg
// Configuration registers and registered pixel total of the decoder
// ----------------------------------------------------------------------------
module tgard_cfg
  import tgard_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  output cfg_t        cfg
);

  logic [2:0]  bpp_r;
  logic [15:0] width_r;
  logic [15:0] height_r;
  logic [31:0] total_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpp_r    <= BPP_RESET;
      width_r  <= '0;
      height_r <= '0;
      total_r  <= '0;
    end else begin
      total_r <= {16'd0, width_r} * {16'd0, height_r};
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_IDX_BPP:    bpp_r    <= cfg_wdata[2:0];
          CFG_IDX_WIDTH:  width_r  <= cfg_wdata;
          CFG_IDX_HEIGHT: height_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  assign cfg.bpp   = eff_bpp(bpp_r);
  assign cfg.total = total_r;

endmodule

/* src/tgard_in_reg.sv */
// ----------------------------------------------------------------------------
// tgard_in_reg
// Input byte register with stall back-pressure from the decode stage
// ----------------------------------------------------------------------------
module tgard_in_reg
  import tgard_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       take,
  output logic       byte_valid,
  output logic [7:0] byte_data
);

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] data_r;
  logic       load;

  assign in_stall  = valid_r && !take;
  assign load      = in_valid && !in_stall;
  assign valid_nxt = load || (valid_r && !take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= in_data_byte;
    end
  end

  assign byte_valid = valid_r;
  assign byte_data  = data_r;

endmodule

/* src/tgard_core.sv */
// ----------------------------------------------------------------------------
// tgard_core
// Chunk and pixel decode state with the registered result word
// ----------------------------------------------------------------------------
`include "tga_rle_pixel_decoder_macros.svh"

module tgard_core
  import tgard_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        byte_valid,
  input  logic [7:0]  byte_data,
  output logic        take,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_pixel_value,
  output logic [7:0]  out_repeat_count,
  output logic        out_last_pixel
);

  logic        expect_hdr_r, expect_hdr_nxt;
  logic        run_r, run_nxt;
  logic [7:0]  left_r, left_nxt;
  logic [1:0]  bip_r, bip_nxt;
  logic [31:0] gather_r, gather_nxt;
  logic [31:0] done_r, done_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] pixel_r;
  logic [7:0]  repeat_r;
  logic        last_r;

  logic        produce;
  logic [31:0] gather_new;
  logic        done_ge;
  logic [31:0] remaining;
  logic [7:0]  rpt_raw;
  logic [7:0]  rpt;
  logic        last_c;

  assign take = byte_valid && (!out_valid_r || !out_stall);

  always_comb begin
    expect_hdr_nxt = expect_hdr_r;
    run_nxt        = run_r;
    left_nxt       = left_r;
    bip_nxt        = bip_r;
    gather_nxt     = gather_r;
    done_nxt       = done_r;
    produce        = 1'b0;
    gather_new     = gather_r | ({24'd0, byte_data} << {bip_r, 3'b000});
    done_ge        = cfg.total <= done_r;
    remaining      = cfg.total - done_r;
    rpt_raw        = (run_r && left_r != 8'd0) ? left_r : 8'd1;
    if (done_ge) begin
      rpt = 8'd1;
    end else if ({24'd0, rpt_raw} > remaining) begin
      rpt = remaining[7:0];
    end else begin
      rpt = rpt_raw;
    end
    last_c = done_ge || ({24'd0, rpt} >= remaining);

    if (take) begin
      if (expect_hdr_r) begin
        if (cfg.total != 32'd0) begin
          run_nxt        = byte_data >= RLE_RUN_FLAG;
          left_nxt       = (byte_data >= RLE_RUN_FLAG) ? byte_data - RLE_RUN_BIAS
                                                       : byte_data + 8'd1;
          expect_hdr_nxt = 1'b0;
          bip_nxt        = '0;
          gather_nxt     = '0;
        end
      end else if (({1'b0, bip_r} + 3'd1) < cfg.bpp) begin
        bip_nxt    = bip_r + 2'd1;
        gather_nxt = gather_new;
      end else begin
        produce    = 1'b1;
        bip_nxt    = '0;
        gather_nxt = '0;
        if (last_c) begin
          done_nxt       = '0;
          expect_hdr_nxt = 1'b1;
          run_nxt        = 1'b0;
          left_nxt       = '0;
        end else begin
          done_nxt = done_r + {24'd0, rpt};
          if (run_r || left_r <= 8'd1) begin
            left_nxt       = '0;
            expect_hdr_nxt = 1'b1;
          end else begin
            left_nxt = left_r - 8'd1;
          end
        end
      end
    end
    out_valid_nxt = produce || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expect_hdr_r <= 1'b1;
      run_r        <= 1'b0;
      left_r       <= '0;
      bip_r        <= '0;
      gather_r     <= '0;
      done_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      expect_hdr_r <= expect_hdr_nxt;
      run_r        <= run_nxt;
      left_r       <= left_nxt;
      bip_r        <= bip_nxt;
      gather_r     <= gather_nxt;
      done_r       <= done_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (produce) begin
      pixel_r  <= gather_new & pixel_mask(cfg.bpp);
      repeat_r <= rpt;
      last_r   <= last_c;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_value  = pixel_r;
  assign out_repeat_count = repeat_r;
  assign out_last_pixel   = last_r;

  `TGARD_ASSERT_IMPL(a_chunk_not_empty, !expect_hdr_r, left_r != 8'd0, "open chunk with no pixels")
  `TGARD_ASSERT_NEXT(a_last_restarts, produce && last_c, expect_hdr_r && done_r == 32'd0, "image end did not restart")
  `TGARD_ASSERT_NEXT(a_progress, produce && !last_c, done_r != 32'd0, "pixel count did not advance")
  `TGARD_ASSERT_NEXT(a_result_count, produce, out_valid_r && out_repeat_count != 8'd0, "result lost or zero count")

endmodule

/* src/tga_rle_pixel_decoder.sv */
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder
// Run-length image pixel decoder, one decoded pixel per result word
// ----------------------------------------------------------------------------
// Takes one stream byte per clock and sustains that rate while the result
// side is not stalled; a byte passes an input register and the decode stage,
// and the result word for the byte that completes a pixel is registered in
// the output register. A result word held by out_stall holds the byte in
// the input register, and in_stall follows within the same cycle.
// Each pixel yields one word with its repeat count (1 for raw pixels, clipped
// to the pixels left), and last_pixel marks the end of the image, after which
// the next byte is taken as the next image's first chunk header. The pixel
// total is registered from width and height, so write the configuration only
// while the block is idle.
module tga_rle_pixel_decoder
  import tgard_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_pixel_value,
  output logic [7:0]  out_repeat_count,
  output logic        out_last_pixel
);

  cfg_t       cfg;
  logic       take;
  logic       byte_valid;
  logic [7:0] byte_data;

  tgard_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  tgard_in_reg u_in_reg (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .take         (take),
    .byte_valid   (byte_valid),
    .byte_data    (byte_data)
  );

  tgard_core u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .byte_valid       (byte_valid),
    .byte_data        (byte_data),
    .take             (take),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pixel_value  (out_pixel_value),
    .out_repeat_count (out_repeat_count),
    .out_last_pixel   (out_last_pixel)
  );

endmodule
